FILE: rtl/dqr_pkg.sv
// Shared types and constants for the DNS query responder.
// Depends on nothing; used by every module of the block.
`default_nettype none
package dqr_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NAME    = 3'd1,
        PH_POINTER = 3'd2,
        PH_TAIL    = 3'd3,
        PH_SKIP    = 3'd4
    } t_phase;

    localparam logic [1:0] ST_MORE    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_DISCARD = 2'd2;

    // configuration register indexes
    localparam logic CFG_ADDRESS = 1'b0;
    localparam logic CFG_TTL     = 1'b1;

    localparam logic [31:0] ADDRESS_RESET = 32'hC0A8_0401;
    localparam logic [31:0] TTL_RESET     = 32'd60;

    localparam logic [7:0] PTR_HI_BYTE   = 8'hC0;
    localparam logic [7:0] PTR_LO_BYTE   = 8'h0C;
    localparam logic [7:0] REPLY_FLAGS   = 8'h80;
    localparam logic [2:0] TAIL_BYTES    = 3'd4;

    // command queue between parser and emitter
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic [1:0] status;
        logic       answer;   // emit data, then the 16-byte A answer
    } t_cmd;

endpackage
`default_nettype wire

FILE: rtl/dqr_parser.sv
// Front end: accepts query bytes, walks header and QNAME, issues commands.
// Depends on dqr_pkg.
`default_nettype none
module dqr_parser #(
    parameter int MAX_QUERY_BYTES = 256
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_accept,
    input  wire  [7:0]       i_data_byte,
    input  wire              i_last_byte,
    output logic             o_push,
    output dqr_pkg::t_cmd    o_cmd
);
    localparam int PW = $clog2(MAX_QUERY_BYTES + 1);
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_QUERY_BYTES);

    logic [PW-1:0]    r_pos, n_pos;
    dqr_pkg::t_phase  r_phase, n_phase;
    logic [7:0]       r_label, n_label;
    logic [2:0]       r_tail, n_tail;
    logic             r_chn, n_chn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= dqr_pkg::PH_HEADER;
            r_label <= '0;
            r_tail  <= dqr_pkg::TAIL_BYTES;
            r_chn   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_label <= n_label;
            r_tail  <= n_tail;
            r_chn   <= n_chn;
        end
    end

    always_comb begin
        logic       restart;
        logic       handled;
        logic       drop;
        logic [7:0] rb;
        restart = 1'b0;
        handled = 1'b0;
        drop    = 1'b0;
        rb      = i_data_byte;
        n_pos   = r_pos;
        n_phase = r_phase;
        n_label = r_label;
        n_tail  = r_tail;
        n_chn   = r_chn;
        o_push  = 1'b0;
        o_cmd   = '{data: 8'h00, present: 1'b0, status: dqr_pkg::ST_DISCARD, answer: 1'b0};

        if (i_accept) begin
            if (r_phase == dqr_pkg::PH_SKIP) begin
                restart = i_last_byte;
            end else if (r_pos >= MAX_POS) begin
                drop = 1'b1;
            end else begin
                n_pos = r_pos + PW'(1);
                case (r_phase)
                    dqr_pkg::PH_HEADER: begin
                        case (r_pos)
                            PW'(0), PW'(1): rb = i_data_byte;
                            PW'(2): begin
                                rb = dqr_pkg::REPLY_FLAGS;
                                drop = i_data_byte[7];   // response bit set
                            end
                            PW'(3): rb = dqr_pkg::REPLY_FLAGS;
                            PW'(4): begin
                                n_chn = (i_data_byte != 8'h00);
                                rb = 8'h00;
                            end
                            PW'(5): begin
                                rb = 8'h01;
                                drop = !r_chn && (i_data_byte == 8'h00);
                            end
                            PW'(6): rb = 8'h00;
                            PW'(7): rb = 8'h01;
                            PW'(11): begin
                                rb = 8'h00;
                                n_phase = dqr_pkg::PH_NAME;
                            end
                            default: rb = 8'h00;
                        endcase
                    end
                    dqr_pkg::PH_NAME: begin
                        if (r_label != 8'h00) begin
                            n_label = r_label - 8'd1;
                        end else if (i_data_byte >= dqr_pkg::PTR_HI_BYTE) begin
                            n_phase = dqr_pkg::PH_POINTER;
                        end else if (i_data_byte == 8'h00) begin
                            n_phase = dqr_pkg::PH_TAIL;
                        end else begin
                            n_label = i_data_byte;
                        end
                    end
                    dqr_pkg::PH_POINTER: n_phase = dqr_pkg::PH_TAIL;
                    dqr_pkg::PH_TAIL: begin
                        n_tail = r_tail - 3'd1;
                        if (n_tail == 3'd0) begin
                            // last QCLASS byte: echo it, then the answer burst
                            handled = 1'b1;
                            o_push  = 1'b1;
                            o_cmd   = '{data: i_data_byte, present: 1'b1,
                                        status: dqr_pkg::ST_MORE, answer: 1'b1};
                            if (i_last_byte) begin
                                restart = 1'b1;
                            end else begin
                                n_phase = dqr_pkg::PH_SKIP;
                            end
                        end
                    end
                    default: ;
                endcase

                if (!drop && !handled) begin
                    o_push = 1'b1;
                    if (i_last_byte) begin
                        restart = 1'b1;   // early end: bare discard
                    end else begin
                        o_cmd = '{data: rb, present: 1'b1,
                                  status: dqr_pkg::ST_MORE, answer: 1'b0};
                    end
                end
            end

            if (drop) begin
                o_push = 1'b1;
                o_cmd  = '{data: 8'h00, present: 1'b0,
                           status: dqr_pkg::ST_DISCARD, answer: 1'b0};
                if (i_last_byte) begin
                    restart = 1'b1;
                end else begin
                    n_phase = dqr_pkg::PH_SKIP;
                end
            end
        end

        if (restart) begin
            n_pos   = '0;
            n_phase = dqr_pkg::PH_HEADER;
            n_label = '0;
            n_tail  = dqr_pkg::TAIL_BYTES;
            n_chn   = 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dqr_cmd_queue.sv
// Small command queue between parser and emitter.
// Depends on dqr_pkg.
`default_nettype none
module dqr_cmd_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  dqr_pkg::t_cmd    i_cmd,
    input  wire              i_pop,
    output dqr_pkg::t_cmd    o_cmd,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = dqr_pkg::CMDQ_AW;
    localparam int CW = dqr_pkg::CMDQ_AW + 1;

    dqr_pkg::t_cmd                   r_mem [dqr_pkg::CMDQ_DEPTH];
    logic [dqr_pkg::CMDQ_AW-1:0]     r_wr, r_rd;
    logic [CW-1:0]                   r_cnt;
    logic                            push_ok, pop_ok;

    assign o_full  = (r_cnt == CW'(dqr_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wr <= r_wr + AW'(1);
            if (pop_ok)  r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + CW'(push_ok) - CW'(pop_ok);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dqr_emitter.sv
// Back end: drains commands, expands the A answer, holds config and output reg.
// Depends on dqr_pkg.
`default_nettype none
module dqr_emitter (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_index,
    input  wire  [31:0]      i_cfg_data,
    input  dqr_pkg::t_cmd    i_cmd,
    input  wire              i_empty,
    output logic             o_pop,
    input  wire              i_out_stall,
    output logic             o_out_valid,
    output logic [7:0]       o_reply_byte,
    output logic             o_byte_present,
    output logic [1:0]       o_reply_status
);
    logic [31:0] r_addr, r_ttl;
    logic [4:0]  r_cnt;        // 0: idle, 1..16: next answer byte is r_cnt-1
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_present;
    logic [1:0]  r_status;
    logic        adv, burst;
    logic [3:0]  idx;
    logic [7:0]  ans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= dqr_pkg::ADDRESS_RESET;
            r_ttl  <= dqr_pkg::TTL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == dqr_pkg::CFG_ADDRESS) r_addr <= i_cfg_data;
            if (i_cfg_index == dqr_pkg::CFG_TTL)     r_ttl  <= i_cfg_data;
        end
    end

    assign adv   = !r_valid || !i_out_stall;
    assign burst = (r_cnt != 5'd0);
    assign idx   = 4'(r_cnt - 5'd1);
    assign o_pop = adv && !burst && !i_empty;

    always_comb begin
        case (idx)
            4'd0:    ans = dqr_pkg::PTR_HI_BYTE;
            4'd1:    ans = dqr_pkg::PTR_LO_BYTE;
            4'd2:    ans = 8'h00;
            4'd3:    ans = 8'h01;   // TYPE A
            4'd4:    ans = 8'h00;
            4'd5:    ans = 8'h01;   // CLASS IN
            4'd6:    ans = r_ttl[31:24];
            4'd7:    ans = r_ttl[23:16];
            4'd8:    ans = r_ttl[15:8];
            4'd9:    ans = r_ttl[7:0];
            4'd10:   ans = 8'h00;
            4'd11:   ans = 8'h04;   // RDLENGTH
            4'd12:   ans = r_addr[31:24];
            4'd13:   ans = r_addr[23:16];
            4'd14:   ans = r_addr[15:8];
            default: ans = r_addr[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (adv) begin
            if (burst) begin
                r_valid <= 1'b1;
                r_cnt   <= (r_cnt == 5'd16) ? 5'd0 : r_cnt + 5'd1;
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_cnt   <= i_cmd.answer ? 5'd1 : 5'd0;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (burst) begin
                r_byte    <= ans;
                r_present <= 1'b1;
                r_status  <= (idx == 4'd15) ? dqr_pkg::ST_DONE : dqr_pkg::ST_MORE;
            end else begin
                r_byte    <= i_cmd.data;
                r_present <= i_cmd.present;
                r_status  <= i_cmd.status;
            end
        end
    end

    assign o_out_valid    = r_valid;
    assign o_reply_byte   = r_byte;
    assign o_byte_present = r_present;
    assign o_reply_status = r_status;

endmodule
`default_nettype wire

FILE: rtl/dns_query_responder_core.sv
// DNS query responder: forges an A-record reply from a streamed query.
// Top level; instantiates dqr_parser, dqr_cmd_queue, dqr_emitter (dqr_pkg).
//
// Usage:
//  - Input channel: one query byte per transaction (i_data_byte, i_last_byte
//    on the final byte), qualified by i_in_valid, held off by o_in_stall.
//  - Output channel: one result per transaction (o_reply_byte,
//    o_byte_present, o_reply_status), qualified by o_out_valid, held off by
//    i_out_stall. Status: more follows, reply complete, or discard.
//  - Config: i_cfg_we writes i_cfg_data to answer_address (index 0) or
//    answer_ttl (index 1); write only while the block is idle.
//  - Path: an accepted byte's result is queued, then registered at the output.
//  - Throughput: one byte per cycle while o_in_stall is low. The last QCLASS
//    byte expands into 17 results in the emitter; the 4-entry command queue
//    absorbs part of that, then o_in_stall rises until the burst drains.
//  - Stall: i_out_stall freezes the output register; the queue then fills
//    and o_in_stall rises. o_in_stall depends only on queue occupancy.
//  - Reset (synchronous, active low): queue empty, parser at header start,
//    registers back to 192.168.4.1 and TTL 60.
`default_nettype none
module dns_query_responder_core #(
    parameter int MAX_QUERY_BYTES = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_last_byte,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_reply_byte,
    output logic        o_byte_present,
    output logic [1:0]  o_reply_status,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    logic           accept;
    logic           push, pop, full, empty;
    dqr_pkg::t_cmd  push_cmd, head_cmd;

    // input transaction completes only when the queue has room
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    dqr_parser #(
        .MAX_QUERY_BYTES (MAX_QUERY_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    dqr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    dqr_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (head_cmd),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_reply_byte   (o_reply_byte),
        .o_byte_present (o_byte_present),
        .o_reply_status (o_reply_status)
    );

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for dns_query_responder_core: streams DNS queries byte by
// byte and checks every reply result against an in-bench model of the forger.
// Depends on rtl/dqr_pkg.sv and the core RTL.
module tb;

    localparam int MAX_BYTES      = 256;
    localparam int SETTLE_CYCLES  = 8;     // quiet margin after the last result
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SHOWN_ERRORS   = 10;
    localparam int PHASE_BYTES    = 6;     // minimum bytes sent per idling phase

    // header byte offsets
    localparam logic [8:0] OFS_ID_HI    = 9'd0;
    localparam logic [8:0] OFS_ID_LO    = 9'd1;
    localparam logic [8:0] OFS_FLAGS_HI = 9'd2;
    localparam logic [8:0] OFS_FLAGS_LO = 9'd3;
    localparam logic [8:0] OFS_QD_HI    = 9'd4;
    localparam logic [8:0] OFS_QD_LO    = 9'd5;
    localparam logic [8:0] OFS_AN_LO    = 9'd7;
    localparam logic [8:0] OFS_HDR_END  = 9'd11;

    // fixed fields of the A answer record
    localparam logic [15:0] RR_TYPE_A   = 16'h0001;
    localparam logic [15:0] RR_CLASS_IN = 16'h0001;
    localparam logic [15:0] RR_LEN_V4   = 16'h0004;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic [1:0] status;
    } t_reply;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = dqr_pkg::CFG_ADDRESS;
    logic [31:0] i_cfg_data  = 32'h0;
    wire         o_in_stall;
    wire         o_out_valid;
    wire  [7:0]  o_reply_byte;
    wire         o_byte_present;
    wire  [1:0]  o_reply_status;

    dns_query_responder_core #(
        .MAX_QUERY_BYTES(MAX_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_reply_byte  (o_reply_byte),
        .o_byte_present(o_byte_present),
        .o_reply_status(o_reply_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state: expected replies, forger model state, counters
    // ------------------------------------------------------------------
    t_reply      pending_replies[$];
    logic [7:0]  pkt_bytes[$];         // query being assembled

    logic [31:0]      answer_addr;
    logic [31:0]      answer_ttl;
    logic [8:0]       rx_pos;          // saturates at MAX_BYTES
    dqr_pkg::t_phase  rx_phase;
    logic [7:0]       label_left;
    logic [2:0]       tail_left;
    logic             qd_hi_set;

    int idle_pct  = 0;
    int stall_pct = 0;
    int error_count     = 0;
    int bytes_sent      = 0;
    int packets_sent    = 0;
    int replies_checked = 0;
    int answers_seen    = 0;
    int discards_seen   = 0;
    int quiet_cycles    = 0;

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Reply forger model
    // ------------------------------------------------------------------
    task automatic restart_parse();
        rx_pos     = 9'd0;
        rx_phase   = dqr_pkg::PH_HEADER;
        label_left = 8'd0;
        tail_left  = dqr_pkg::TAIL_BYTES;
        qd_hi_set  = 1'b0;
    endtask

    task automatic push_reply(input logic [7:0] data, input logic present,
                              input logic [1:0] status);
        t_reply r;
        r.data    = data;
        r.present = present;
        r.status  = status;
        pending_replies.push_back(r);
    endtask

    // bare discard item, then either a fresh packet or skip the rest
    task automatic drop_reply(input logic last);
        push_reply(8'h00, 1'b0, dqr_pkg::ST_DISCARD);
        if (last)
            restart_parse();
        else
            rx_phase = dqr_pkg::PH_SKIP;
    endtask

    task automatic forge_reply(input logic [7:0] value, input logic last);
        logic [7:0]   out_byte;
        logic [8:0]   pos;
        logic [127:0] answer;
        out_byte = value;
        pos      = rx_pos;
        // after completion or a discard, bytes are swallowed until the end
        if (rx_phase == dqr_pkg::PH_SKIP) begin
            if (last)
                restart_parse();
            return;
        end
        if (pos >= 9'(MAX_BYTES)) begin
            drop_reply(last);
            return;
        end
        rx_pos = pos + 9'd1;

        case (rx_phase)
            dqr_pkg::PH_HEADER: begin
                case (pos)
                    OFS_ID_HI, OFS_ID_LO: out_byte = value;
                    OFS_FLAGS_HI: begin
                        // a response, not a query
                        if (value[7]) begin
                            drop_reply(last);
                            return;
                        end
                        out_byte = dqr_pkg::REPLY_FLAGS;
                    end
                    OFS_FLAGS_LO: out_byte = dqr_pkg::REPLY_FLAGS;
                    OFS_QD_HI: begin
                        qd_hi_set = (value != 8'h00);
                        out_byte  = 8'h00;
                    end
                    OFS_QD_LO: begin
                        // no question to answer
                        if (!qd_hi_set && value == 8'h00) begin
                            drop_reply(last);
                            return;
                        end
                        out_byte = 8'h01;
                    end
                    OFS_AN_LO: out_byte = 8'h01;
                    OFS_HDR_END: begin
                        out_byte = 8'h00;
                        rx_phase = dqr_pkg::PH_NAME;
                    end
                    default: out_byte = 8'h00;
                endcase
            end
            dqr_pkg::PH_NAME: begin
                if (label_left != 8'd0)
                    label_left = label_left - 8'd1;
                else if (value >= dqr_pkg::PTR_HI_BYTE)
                    rx_phase = dqr_pkg::PH_POINTER;   // compression: one more byte
                else if (value == 8'h00)
                    rx_phase = dqr_pkg::PH_TAIL;
                else
                    label_left = value;
            end
            dqr_pkg::PH_POINTER: rx_phase = dqr_pkg::PH_TAIL;
            dqr_pkg::PH_TAIL: begin
                tail_left = tail_left - 3'd1;
                if (tail_left == 3'd0) begin
                    // last QCLASS byte, then the 16-byte answer record
                    answer = {dqr_pkg::PTR_HI_BYTE, dqr_pkg::PTR_LO_BYTE, RR_TYPE_A,
                              RR_CLASS_IN, answer_ttl, RR_LEN_V4, answer_addr};
                    push_reply(value, 1'b1, dqr_pkg::ST_MORE);
                    for (int i = 15; i >= 0; i--)
                        push_reply(answer[i*8 +: 8], 1'b1,
                                   (i == 0) ? dqr_pkg::ST_DONE : dqr_pkg::ST_MORE);
                    if (last)
                        restart_parse();
                    else
                        rx_phase = dqr_pkg::PH_SKIP;
                    return;
                end
            end
            default: ;
        endcase

        // end of packet before the reply completed
        if (last) begin
            push_reply(8'h00, 1'b0, dqr_pkg::ST_DISCARD);
            restart_parse();
        end else begin
            push_reply(out_byte, 1'b1, dqr_pkg::ST_MORE);
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Valid is left high after acceptance; the next call either raises it
    // again with new payload or drops it for a gap, never both in one step.
    task automatic send_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= value;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        forge_reply(value, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int k = 0; k < pkt_bytes.size(); k++)
            send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1);
        pkt_bytes.delete();
        packets_sent++;
    endtask

    // wait for every expected result, then a few quiet cycles
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called while the core is idle
    task automatic load_answer(input logic [31:0] addr, input logic [31:0] ttl);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= dqr_pkg::CFG_ADDRESS;
        i_cfg_data  <= addr;
        @(posedge i_clk);
        i_cfg_index <= dqr_pkg::CFG_TTL;
        i_cfg_data  <= ttl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        answer_addr = addr;
        answer_ttl  = ttl;
    endtask

    // ------------------------------------------------------------------
    // Packet builders
    // ------------------------------------------------------------------
    task automatic put_header(input logic [15:0] id, input logic [7:0] flags_hi,
                              input logic [7:0] qd_hi, input logic [7:0] qd_lo);
        pkt_bytes.push_back(id[15:8]);
        pkt_bytes.push_back(id[7:0]);
        pkt_bytes.push_back(flags_hi);
        pkt_bytes.push_back(8'($urandom_range(255)));
        pkt_bytes.push_back(qd_hi);
        pkt_bytes.push_back(qd_lo);
        repeat (6) pkt_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_label(input int len);
        pkt_bytes.push_back(8'(len));
        repeat (len) pkt_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_tail();
        repeat (4) pkt_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_random_bytes(input int count);
        repeat (count) pkt_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic trim_packet(input int len);
        while (pkt_bytes.size() > len)
            void'(pkt_bytes.pop_back());
    endtask

    // well-formed query with random content
    task automatic put_query();
        logic [7:0] qd_hi;
        logic [7:0] qd_lo;
        qd_hi = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00;
        qd_lo = 8'($urandom_range(255));
        if (qd_hi == 8'h00 && qd_lo == 8'h00)
            qd_lo = 8'h01;
        put_header(16'($urandom_range(16'hFFFF)), 8'($urandom_range(127)), qd_hi, qd_lo);
        repeat ($urandom_range(3)) put_label($urandom_range(1, 12));
        if ($urandom_range(19) == 0)
            put_label($urandom_range(64, 80));
        if ($urandom_range(6) == 0) begin
            pkt_bytes.push_back(8'($urandom_range(255, 192)));
            pkt_bytes.push_back(8'($urandom_range(255)));
        end else begin
            pkt_bytes.push_back(8'h00);
        end
        put_tail();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset register values, root name, trailing bytes after completion.
    task automatic test_basic_query();
        put_header(16'hFFFF, 8'h01, 8'h00, 8'h01);
        pkt_bytes.push_back(8'h00);
        put_tail();
        pkt_bytes.push_back(8'hFF);
        pkt_bytes.push_back(8'h00);
        send_packet();
        settle();
        load_answer(32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_response_bit();
        put_header(16'h0000, 8'h80, 8'h00, 8'h01);
        trim_packet(4);
        send_packet();
        put_header(16'h1234, 8'hFF, 8'h00, 8'h01);
        trim_packet(3);                       // end right on the flags byte
        send_packet();
        settle();
    endtask

    // QDCOUNT zero is dropped; high byte set with low byte zero is not
    task automatic test_zero_questions();
        put_header(16'($urandom_range(16'hFFFF)), 8'h00, 8'h00, 8'h00);
        trim_packet(7);
        send_packet();
        put_header(16'($urandom_range(16'hFFFF)), 8'h00, 8'h01, 8'h00);
        pkt_bytes.push_back(8'h00);
        put_tail();
        send_packet();
        settle();
    endtask

    task automatic test_compression();
        put_header(16'($urandom_range(16'hFFFF)), 8'h7F, 8'h00, 8'h01);
        put_label(3);
        pkt_bytes.push_back(dqr_pkg::PTR_HI_BYTE);
        pkt_bytes.push_back(dqr_pkg::PTR_LO_BYTE);
        put_tail();
        send_packet();
        put_header(16'($urandom_range(16'hFFFF)), 8'h00, 8'h00, 8'h01);
        pkt_bytes.push_back(8'hFF);
        pkt_bytes.push_back(8'h00);
        put_tail();
        send_packet();
        settle();
        load_answer(32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_early_end();
        pkt_bytes.push_back(8'hA5);           // one-byte packet
        send_packet();
        put_header(16'($urandom_range(16'hFFFF)), 8'h00, 8'h00, 8'h01);
        put_label(5);
        trim_packet(15);                      // ends inside the label
        send_packet();
        settle();
    endtask

    // Name runs past the capture limit: discard at the limit, skip the rest.
    // Labels of length 0x40 and 0xBF are walked as ordinary labels on the way.
    task automatic test_capture_limit();
        put_header(16'($urandom_range(16'hFFFF)), 8'h00, 8'h00, 8'h01);
        put_label(8'h40);
        put_label(8'hBF);
        trim_packet(MAX_BYTES + 2);           // limit byte plus one skipped byte
        send_packet();
        settle();
    endtask

    // Four idling phases, each with its own answer setting.
    task automatic test_random_traffic();
        int phase_start;
        int kind;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct = 0; stall_pct = 0;
                    load_answer(32'hFFFF_FFFF, 32'h0000_0000);
                end
                1: begin
                    idle_pct = 64; stall_pct = 0;
                    load_answer($urandom, $urandom);
                end
                2: begin
                    idle_pct = 0; stall_pct = 64;
                    load_answer(32'h0000_0000, 32'hFFFF_FFFF);
                end
                default: begin
                    idle_pct = 10; stall_pct = 10;
                    load_answer($urandom, $urandom);
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                kind = $urandom_range(99);
                if (kind < 60) begin
                    put_query();
                    put_random_bytes($urandom_range(2));
                end else if (kind < 70) begin
                    put_query();
                    trim_packet($urandom_range(1, pkt_bytes.size() - 1));
                end else if (kind < 78) begin
                    put_header(16'($urandom_range(16'hFFFF)),
                               8'($urandom_range(255, 128)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                    trim_packet($urandom_range(3, 12));
                end else if (kind < 86) begin
                    put_header(16'($urandom_range(16'hFFFF)), 8'($urandom_range(127)),
                               8'h00, 8'h00);
                    trim_packet($urandom_range(6, 12));
                end else begin
                    put_random_bytes($urandom_range(1, 24));
                end
                send_packet();
            end
            settle();
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, result checking, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            replies_checked++;
            if (pending_replies.size() == 0) begin
                note_error($sformatf("unexpected result byte %02h present %0b status %0d",
                                     o_reply_byte, o_byte_present, o_reply_status));
            end else begin
                want = pending_replies.pop_front();
                if (want.status == dqr_pkg::ST_DONE)
                    answers_seen++;
                if (want.status == dqr_pkg::ST_DISCARD)
                    discards_seen++;
                if (o_reply_byte !== want.data || o_byte_present !== want.present ||
                    o_reply_status !== want.status)
                    note_error($sformatf({"byte %02h/%02h present %0b/%0b ",
                                          "status %0d/%0d (expected/actual)"},
                                         want.data, o_reply_byte, want.present,
                                         o_byte_present, want.status, o_reply_status));
            end
        end
    end

    // ends the run if no transaction moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        answer_addr = dqr_pkg::ADDRESS_RESET;
        answer_ttl  = dqr_pkg::TTL_RESET;
        restart_parse();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_query();
        test_response_bit();
        test_zero_questions();
        test_compression();
        test_early_end();
        test_capture_limit();
        test_random_traffic();

        settle();
        if (pending_replies.size() != 0)
            note_error($sformatf("%0d expected results never arrived",
                                 pending_replies.size()));
        $display("run: %0d packets, %0d query bytes, %0d results checked",
                 packets_sent, bytes_sent, replies_checked);
        $display("run: %0d forged answers, %0d discards, 4 answer settings",
                 answers_seen, discards_seen);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
